// ===== sv/lsed_pkg.sv =====
// ----------------------------------------------------------------------------
// lsed_pkg
// shared widths, codes, reset values and types of the line-scan edge and line
// detector
// ----------------------------------------------------------------------------
package lsed_pkg;

    // default module parameters
    localparam int LINE_PIXELS_DEF   = 128;
    localparam int MAX_EDGES_DEF     = 16;
    localparam int DIFF_DISTANCE_DEF = 2;

    // payload and register widths
    localparam int PIX_W    = 8;
    localparam int POS_W    = 7;   // edge position and line width
    localparam int LPOS_W   = 8;   // centred line position
    localparam int CNT_O_W  = 5;   // reported edge count
    localparam int KIND_W   = 2;
    localparam int THR_W    = 8;
    localparam int MARGIN_W = 6;
    localparam int LW_W     = 7;
    localparam int OFS_W    = 7;
    localparam int WIN_W    = 9;   // window compare width, holds index + margin
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int RIDX_W   = 3;

    // register index map, byte address is 4 * index
    localparam logic [RIDX_W-1:0] REG_EDGE_THRESHOLD = 3'd0;
    localparam logic [RIDX_W-1:0] REG_MARGIN         = 3'd1;
    localparam logic [RIDX_W-1:0] REG_MIN_LINE_WIDTH = 3'd2;
    localparam logic [RIDX_W-1:0] REG_MAX_LINE_WIDTH = 3'd3;
    localparam logic [RIDX_W-1:0] REG_MIN_START_GAP  = 3'd4;
    localparam logic [RIDX_W-1:0] REG_MAX_START_GAP  = 3'd5;
    localparam logic [RIDX_W-1:0] REG_CENTER_OFFSET  = 3'd6;

    // register reset values
    localparam logic [THR_W-1:0]    RST_EDGE_THRESHOLD = 8'd15;
    localparam logic [MARGIN_W-1:0] RST_MARGIN         = 6'd2;
    localparam logic [LW_W-1:0]     RST_MIN_LINE_WIDTH = 7'd3;
    localparam logic [LW_W-1:0]     RST_MAX_LINE_WIDTH = 7'd20;
    localparam logic [LW_W-1:0]     RST_MIN_START_GAP  = 7'd3;
    localparam logic [LW_W-1:0]     RST_MAX_START_GAP  = 7'd20;
    localparam logic [OFS_W-1:0]    RST_CENTER_OFFSET  = 7'd0;

    // frame kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_START = 2'd3;

    // start marker tracking codes
    localparam logic [1:0] MARK_IDLE     = 2'd0;
    localparam logic [1:0] MARK_GAP      = 2'd1;
    localparam logic [1:0] MARK_GAP_LINE = 2'd2;

    // edge event from the edge unit to the line judge
    typedef struct packed {
        logic               hit;        // edge found on this pixel
        logic               rising;
        logic               have_prev;  // an earlier edge exists in the frame
        logic [POS_W-1:0]   pos;
        logic [CNT_O_W-1:0] count;      // edge count including this pixel
    } edge_evt_t;

endpackage

// ===== sv/lsed_sample_if.sv =====
// ----------------------------------------------------------------------------
// lsed_sample_if
// pixel channel: one camera sample per beat
// ----------------------------------------------------------------------------
interface lsed_sample_if;

    logic                        valid;
    logic                        ready;
    logic [lsed_pkg::PIX_W-1:0]  pixel;
    logic                        last_pixel;

    modport source (output valid, output pixel, output last_pixel, input ready);
    modport sink   (input valid, input pixel, input last_pixel, output ready);

endinterface

// ===== sv/lsed_result_if.sv =====
// ----------------------------------------------------------------------------
// lsed_result_if
// frame result channel: one beat per scan line
// ----------------------------------------------------------------------------
interface lsed_result_if;

    logic                               valid;
    logic                               ready;
    logic [lsed_pkg::KIND_W-1:0]        frame_kind;
    logic signed [lsed_pkg::LPOS_W-1:0] line_position;
    logic [lsed_pkg::POS_W-1:0]         line_width;
    logic [lsed_pkg::CNT_O_W-1:0]       edge_count;

    modport source (output valid, output frame_kind, output line_position,
                    output line_width, output edge_count, input ready);
    modport sink   (input valid, input frame_kind, input line_position,
                    input line_width, input edge_count, output ready);

endinterface

// ===== sv/line_scan_edge_line_detector_unit.sv =====
// ----------------------------------------------------------------------------
// line_scan_edge_line_detector_unit
// a last pixel is judged from the input register into the result register
// throughput: one pixel per cycle, set by the edge and pair judge
// a result waiting on the output stalls only a following last pixel
// reset: asynchronous active-low rst_n clears frame state, delay line and
// registers to their default values
// ----------------------------------------------------------------------------
module line_scan_edge_line_detector_unit #(
    parameter int LINE_PIXELS   = lsed_pkg::LINE_PIXELS_DEF,
    parameter int MAX_EDGES     = lsed_pkg::MAX_EDGES_DEF,
    parameter int DIFF_DISTANCE = lsed_pkg::DIFF_DISTANCE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lsed_sample_if.sink                  sample,
    lsed_result_if.source                result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsed_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsed_pkg::DATA_W-1:0]  pwdata,
    output logic [lsed_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int POS_W  = lsed_pkg::POS_W;
    localparam int LPOS_W = lsed_pkg::LPOS_W;
    localparam int KIND_W = lsed_pkg::KIND_W;
    localparam int DATA_W = lsed_pkg::DATA_W;
    localparam logic [LPOS_W-1:0] HALF_PIX = LPOS_W'(LINE_PIXELS / 2);

    // configuration registers
    logic [lsed_pkg::THR_W-1:0]    edge_threshold_reg;
    logic [lsed_pkg::MARGIN_W-1:0] margin_reg;
    logic [lsed_pkg::LW_W-1:0]     min_line_width_reg;
    logic [lsed_pkg::LW_W-1:0]     max_line_width_reg;
    logic [lsed_pkg::LW_W-1:0]     min_start_gap_reg;
    logic [lsed_pkg::LW_W-1:0]     max_start_gap_reg;
    logic [lsed_pkg::OFS_W-1:0]    center_offset_reg;

    logic                          cfg_wr;
    logic [lsed_pkg::RIDX_W-1:0]   cfg_idx;

    // input stage
    logic                          in_valid_reg, in_valid_next;
    logic [lsed_pkg::PIX_W-1:0]    pixel_reg;
    logic                          last_reg;
    logic                          step;

    // frame state
    logic [POS_W-1:0]              prev_pos_reg, prev_pos_next;
    logic                          prev_rising_reg, prev_rising_next;
    logic [1:0]                    marker_reg, marker_next;
    logic [KIND_W-1:0]             kind_reg, kind_next;
    logic [LPOS_W-1:0]             position_reg, position_next;
    logic [POS_W-1:0]              width_reg, width_next;

    // result stage
    logic                          out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]             out_kind_reg;
    logic [LPOS_W-1:0]             out_position_reg;
    logic [POS_W-1:0]              out_width_reg;
    logic [lsed_pkg::CNT_O_W-1:0]  out_count_reg;

    lsed_pkg::edge_evt_t           evt;
    logic [POS_W-1:0]              pair_width;
    logic [POS_W:0]                pair_sum;
    logic                          line_ok;
    logic                          gap_ok;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[lsed_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_threshold_reg <= lsed_pkg::RST_EDGE_THRESHOLD;
            margin_reg         <= lsed_pkg::RST_MARGIN;
            min_line_width_reg <= lsed_pkg::RST_MIN_LINE_WIDTH;
            max_line_width_reg <= lsed_pkg::RST_MAX_LINE_WIDTH;
            min_start_gap_reg  <= lsed_pkg::RST_MIN_START_GAP;
            max_start_gap_reg  <= lsed_pkg::RST_MAX_START_GAP;
            center_offset_reg  <= lsed_pkg::RST_CENTER_OFFSET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lsed_pkg::REG_EDGE_THRESHOLD: edge_threshold_reg <= pwdata[7:0];
                lsed_pkg::REG_MARGIN:         margin_reg         <= pwdata[5:0];
                lsed_pkg::REG_MIN_LINE_WIDTH: min_line_width_reg <= pwdata[6:0];
                lsed_pkg::REG_MAX_LINE_WIDTH: max_line_width_reg <= pwdata[6:0];
                lsed_pkg::REG_MIN_START_GAP:  min_start_gap_reg  <= pwdata[6:0];
                lsed_pkg::REG_MAX_START_GAP:  max_start_gap_reg  <= pwdata[6:0];
                lsed_pkg::REG_CENTER_OFFSET:  center_offset_reg  <= pwdata[6:0];
                default:                      ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            lsed_pkg::REG_EDGE_THRESHOLD: prdata = DATA_W'(edge_threshold_reg);
            lsed_pkg::REG_MARGIN:         prdata = DATA_W'(margin_reg);
            lsed_pkg::REG_MIN_LINE_WIDTH: prdata = DATA_W'(min_line_width_reg);
            lsed_pkg::REG_MAX_LINE_WIDTH: prdata = DATA_W'(max_line_width_reg);
            lsed_pkg::REG_MIN_START_GAP:  prdata = DATA_W'(min_start_gap_reg);
            lsed_pkg::REG_MAX_START_GAP:  prdata = DATA_W'(max_start_gap_reg);
            lsed_pkg::REG_CENTER_OFFSET:
                prdata = {{(DATA_W-lsed_pkg::OFS_W){center_offset_reg[lsed_pkg::OFS_W-1]}},
                          center_offset_reg};
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // input register; a last pixel waits while the result stage is full
    // ------------------------------------------------------------------------
    assign step          = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign sample.ready  = !in_valid_reg || step;
    assign in_valid_next = (sample.valid && sample.ready) || (in_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            pixel_reg <= sample.pixel;
            last_reg  <= sample.last_pixel;
        end
    end

    // ------------------------------------------------------------------------
    // edge detection
    // ------------------------------------------------------------------------
    lsed_edge_unit #(
        .LINE_PIXELS   (LINE_PIXELS),
        .MAX_EDGES     (MAX_EDGES),
        .DIFF_DISTANCE (DIFF_DISTANCE)
    ) u_edge (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .pixel          (pixel_reg),
        .last_pixel     (last_reg),
        .edge_threshold (edge_threshold_reg),
        .margin         (margin_reg),
        .evt            (evt)
    );

    // ------------------------------------------------------------------------
    // pair judge: falling-rising is a line, rising-falling is a gap
    // ------------------------------------------------------------------------
    always_comb
    begin
        pair_width = evt.pos - prev_pos_reg;
        pair_sum   = {1'b0, evt.pos} + {1'b0, prev_pos_reg};
        line_ok    = evt.hit && evt.have_prev && !prev_rising_reg && evt.rising &&
                     (pair_width > min_line_width_reg) && (pair_width < max_line_width_reg);
        gap_ok     = evt.hit && evt.have_prev && prev_rising_reg && !evt.rising &&
                     (pair_width > min_start_gap_reg) && (pair_width < max_start_gap_reg);
    end

    always_comb
    begin
        prev_pos_next    = prev_pos_reg;
        prev_rising_next = prev_rising_reg;
        marker_next      = marker_reg;
        kind_next        = kind_reg;
        position_next    = position_reg;
        width_next       = width_reg;
        if (line_ok)
        begin
            position_next = LPOS_W'(pair_sum[POS_W:1]) - HALF_PIX -
                            {center_offset_reg[lsed_pkg::OFS_W-1], center_offset_reg};
            width_next    = pair_width;
            kind_next     = (kind_reg == lsed_pkg::KIND_NONE) ? lsed_pkg::KIND_LINE
                                                              : lsed_pkg::KIND_ERROR;
            marker_next   = (marker_reg == lsed_pkg::MARK_GAP) ? lsed_pkg::MARK_GAP_LINE
                                                               : lsed_pkg::MARK_IDLE;
        end
        if (gap_ok)
        begin
            if (marker_reg == lsed_pkg::MARK_GAP_LINE)
            begin
                kind_next = lsed_pkg::KIND_START;
            end
            marker_next = lsed_pkg::MARK_GAP;
        end
        if (evt.hit)
        begin
            prev_pos_next    = evt.pos;
            prev_rising_next = evt.rising;
        end
    end

    // frame state, cleared once the last pixel is judged
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg    <= '0;
            prev_rising_reg <= 1'b0;
            marker_reg      <= lsed_pkg::MARK_IDLE;
            kind_reg        <= lsed_pkg::KIND_NONE;
            position_reg    <= '0;
            width_reg       <= '0;
        end
        else if (step)
        begin
            if (last_reg)
            begin
                prev_pos_reg    <= '0;
                prev_rising_reg <= 1'b0;
                marker_reg      <= lsed_pkg::MARK_IDLE;
                kind_reg        <= lsed_pkg::KIND_NONE;
                position_reg    <= '0;
                width_reg       <= '0;
            end
            else
            begin
                prev_pos_reg    <= prev_pos_next;
                prev_rising_reg <= prev_rising_next;
                marker_reg      <= marker_next;
                kind_reg        <= kind_next;
                position_reg    <= position_next;
                width_reg       <= width_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------------
    assign out_valid_next = (step && last_reg) || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
        begin
            out_kind_reg     <= kind_next;
            out_position_reg <= position_next;
            out_width_reg    <= width_next;
            out_count_reg    <= evt.count;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.frame_kind    = out_kind_reg;
    assign result.line_position = out_position_reg;
    assign result.line_width    = out_width_reg;
    assign result.edge_count    = out_count_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a result beat appears only from a judged last pixel
    a_result_from_last : assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(step && last_reg)) |=> !out_valid_reg)
        else $error("result appeared without a last pixel");

    // a pending pixel is not overwritten while it waits
    a_input_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(pixel_reg) && $stable(last_reg)))
        else $error("pending pixel lost");

    // any kind other than none comes with a recorded line width
    a_kind_has_width : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != lsed_pkg::KIND_NONE)) |-> (out_width_reg != '0))
        else $error("line kind reported without a line width");

    // edge count stays within the edge limit
    a_count_limit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((MAX_EDGES > 31) || (out_count_reg <= MAX_EDGES)))
        else $error("edge count above limit");

endmodule

// ===== sv/lsed_edge_unit.sv =====
// ----------------------------------------------------------------------------
// lsed_edge_unit
// sample delay line, pixel index, window check, derivative threshold, edge
// skip and edge counter; reports one edge event per processed pixel
// ----------------------------------------------------------------------------
module lsed_edge_unit #(
    parameter int LINE_PIXELS   = lsed_pkg::LINE_PIXELS_DEF,
    parameter int MAX_EDGES     = lsed_pkg::MAX_EDGES_DEF,
    parameter int DIFF_DISTANCE = lsed_pkg::DIFF_DISTANCE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [lsed_pkg::PIX_W-1:0]    pixel,
    input  logic                          last_pixel,
    input  logic [lsed_pkg::THR_W-1:0]    edge_threshold,
    input  logic [lsed_pkg::MARGIN_W-1:0] margin,
    output lsed_pkg::edge_evt_t           evt
);

    localparam int IDX_W  = $clog2(LINE_PIXELS + 1);
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int SKIP_W = $clog2(DIFF_DISTANCE + 1);
    localparam int WIN_W  = lsed_pkg::WIN_W;
    localparam int PIX_W  = lsed_pkg::PIX_W;

    logic [PIX_W-1:0]  delay_reg [DIFF_DISTANCE];
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              in_line;
    logic              win_ok;
    logic [PIX_W:0]    diff;
    logic [PIX_W:0]    mag;
    logic              hit;

    // derivative against the sample DIFF_DISTANCE pixels back
    always_comb
    begin
        in_line = idx_reg < IDX_W'(LINE_PIXELS);
        win_ok  = (WIN_W'(idx_reg) >= WIN_W'(margin) + WIN_W'(DIFF_DISTANCE)) &&
                  (WIN_W'(idx_reg) + WIN_W'(margin) < WIN_W'(LINE_PIXELS));
        diff    = {1'b0, pixel} - {1'b0, delay_reg[DIFF_DISTANCE-1]};
        mag     = diff[PIX_W] ? ((PIX_W+1)'(0) - diff) : diff;
        hit     = step && in_line && (skip_reg == '0) && win_ok &&
                  (cnt_reg < CNT_W'(MAX_EDGES)) && (mag > {1'b0, edge_threshold});
    end

    // index, skip and count update, cleared after the last pixel
    always_comb
    begin
        idx_next  = idx_reg;
        skip_next = skip_reg;
        cnt_next  = cnt_reg;
        if (step && in_line)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - SKIP_W'(1);
            end
            else if (hit)
            begin
                skip_next = SKIP_W'(DIFF_DISTANCE);
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            idx_next = idx_reg + IDX_W'(1);
        end
        if (step && last_pixel)
        begin
            idx_next  = '0;
            skip_next = '0;
            cnt_next  = '0;
        end
    end

    // edge event
    always_comb
    begin
        evt.hit       = hit;
        evt.rising    = ~diff[PIX_W];
        evt.have_prev = cnt_reg != '0;
        evt.pos       = lsed_pkg::POS_W'(idx_reg);
        evt.count     = lsed_pkg::CNT_O_W'(cnt_reg + CNT_W'(hit));
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            skip_reg <= '0;
            cnt_reg  <= '0;
            for (int i = 0; i < DIFF_DISTANCE; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            idx_reg      <= idx_next;
            skip_reg     <= skip_next;
            cnt_reg      <= cnt_next;
            delay_reg[0] <= pixel;
            for (int i = 1; i < DIFF_DISTANCE; i++)
            begin
                delay_reg[i] <= delay_reg[i-1];
            end
        end
    end

endmodule

// ===== tb/sv/line_scan_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_scan_frame_checker
// watches the pixel, result and register ports of the line-scan detector,
// tracks edges, lines and start markers per frame and compares every frame
// result beat field by field with the frame report it predicts
// ----------------------------------------------------------------------------
module line_scan_frame_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    lsed_sample_if                      smp,
    lsed_result_if                      res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [lsed_pkg::ADDR_W-1:0] paddr,
    input  logic [lsed_pkg::DATA_W-1:0] pwdata,
    output int                          failures,
    output int                          pending,
    output int                          checked
);

    localparam int LINE_PX = lsed_pkg::LINE_PIXELS_DEF;
    localparam int MAX_EDG = lsed_pkg::MAX_EDGES_DEF;
    localparam int DIFF    = lsed_pkg::DIFF_DISTANCE_DEF;
    localparam int ADDR_W  = lsed_pkg::ADDR_W;
    localparam int POS_W   = lsed_pkg::POS_W;
    localparam int LPOS_W  = lsed_pkg::LPOS_W;

    typedef struct {
        logic [lsed_pkg::KIND_W-1:0]  kind;
        logic signed [LPOS_W-1:0]     position;
        logic [POS_W-1:0]             width;
        logic [lsed_pkg::CNT_O_W-1:0] count;
    } frame_report_t;

    // frame reports predicted but not yet seen on the result port
    frame_report_t reports_due[$];

    // register copies
    logic [lsed_pkg::THR_W-1:0]        thr_q;
    logic [lsed_pkg::MARGIN_W-1:0]     margin_q;
    logic [lsed_pkg::LW_W-1:0]         min_lw_q;
    logic [lsed_pkg::LW_W-1:0]         max_lw_q;
    logic [lsed_pkg::LW_W-1:0]         min_gap_q;
    logic [lsed_pkg::LW_W-1:0]         max_gap_q;
    logic signed [lsed_pkg::OFS_W-1:0] ofs_q;

    // per-frame tracking
    logic [lsed_pkg::PIX_W-1:0]   tap [DIFF];
    logic [7:0]                   px_index;
    int                           skip_left;
    logic [lsed_pkg::CNT_O_W-1:0] edges_seen;
    logic [POS_W-1:0]             prev_pos;
    logic                         prev_rise;
    logic [1:0]                   mark;
    logic [lsed_pkg::KIND_W-1:0]  kind_acc;
    logic signed [LPOS_W-1:0]     pos_acc;
    logic [POS_W-1:0]             width_acc;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        failures++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, predicted %0d", name, got, want));
    endtask

    task automatic clear_frame_state();
        px_index   = '0;
        skip_left  = 0;
        edges_seen = '0;
        prev_pos   = '0;
        prev_rise  = 1'b0;
        mark       = lsed_pkg::MARK_IDLE;
        kind_acc   = lsed_pkg::KIND_NONE;
        pos_acc    = '0;
        width_acc  = '0;
    endtask

    // judge the pair closed by a new edge at position at
    task automatic judge_pair(input logic [7:0] at, input logic rising);
        logic [POS_W-1:0] w;
        int mid;
        w = at[POS_W-1:0] - prev_pos;
        if (!prev_rise && rising)
        begin
            // dark line between a falling and a rising edge
            if (w > min_lw_q && w < max_lw_q)
            begin
                mid       = (int'(at) + int'(prev_pos)) / 2;
                pos_acc   = LPOS_W'(mid - LINE_PX / 2 - int'(ofs_q));
                width_acc = w;
                kind_acc  = (kind_acc == lsed_pkg::KIND_NONE) ? lsed_pkg::KIND_LINE
                                                              : lsed_pkg::KIND_ERROR;
                mark      = (mark == lsed_pkg::MARK_GAP) ? lsed_pkg::MARK_GAP_LINE
                                                         : lsed_pkg::MARK_IDLE;
            end
        end
        else if (prev_rise && !rising)
        begin
            // bright gap between a rising and a falling edge
            if (w > min_gap_q && w < max_gap_q)
            begin
                if (mark == lsed_pkg::MARK_GAP_LINE)
                    kind_acc = lsed_pkg::KIND_START;
                mark = lsed_pkg::MARK_GAP;
            end
        end
    endtask

    // advance the frame by one accepted pixel beat
    task automatic scan_pixel(input logic [lsed_pkg::PIX_W-1:0] pix, input logic last);
        int dc;
        int mag;
        int lo;
        int hi;
        logic rising;
        lo = int'(margin_q) + DIFF;
        hi = LINE_PX - int'(margin_q);
        if (px_index < LINE_PX)
        begin
            if (skip_left > 0)
            begin
                skip_left--;
            end
            else if (int'(px_index) >= lo && int'(px_index) < hi
                     && edges_seen < MAX_EDG)
            begin
                dc     = int'(pix) - int'(tap[DIFF-1]);
                rising = dc > 0;
                mag    = (dc < 0) ? -dc : dc;
                if (mag > int'(thr_q))
                begin
                    if (edges_seen > 0)
                        judge_pair(px_index, rising);
                    prev_pos  = px_index[POS_W-1:0];
                    prev_rise = rising;
                    edges_seen++;
                    skip_left = DIFF;
                end
            end
            px_index++;
        end
        for (int k = DIFF - 1; k > 0; k--)
            tap[k] = tap[k-1];
        tap[0] = pix;
        if (last)
        begin
            reports_due.push_back('{kind_acc, pos_acc, width_acc, edges_seen});
            clear_frame_state();
        end
    endtask

    // register writes, pixel beats and result beats at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t due;
        if (!rst_n)
        begin
            thr_q     = lsed_pkg::RST_EDGE_THRESHOLD;
            margin_q  = lsed_pkg::RST_MARGIN;
            min_lw_q  = lsed_pkg::RST_MIN_LINE_WIDTH;
            max_lw_q  = lsed_pkg::RST_MAX_LINE_WIDTH;
            min_gap_q = lsed_pkg::RST_MIN_START_GAP;
            max_gap_q = lsed_pkg::RST_MAX_START_GAP;
            ofs_q     = lsed_pkg::RST_CENTER_OFFSET;
            for (int k = 0; k < DIFF; k++)
                tap[k] = '0;
            clear_frame_state();
            reports_due.delete();
            failures = 0;
            pending  = 0;
            checked  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    lsed_pkg::REG_EDGE_THRESHOLD:
                        thr_q = pwdata[lsed_pkg::THR_W-1:0];
                    lsed_pkg::REG_MARGIN:
                        margin_q = pwdata[lsed_pkg::MARGIN_W-1:0];
                    lsed_pkg::REG_MIN_LINE_WIDTH:
                        min_lw_q = pwdata[lsed_pkg::LW_W-1:0];
                    lsed_pkg::REG_MAX_LINE_WIDTH:
                        max_lw_q = pwdata[lsed_pkg::LW_W-1:0];
                    lsed_pkg::REG_MIN_START_GAP:
                        min_gap_q = pwdata[lsed_pkg::LW_W-1:0];
                    lsed_pkg::REG_MAX_START_GAP:
                        max_gap_q = pwdata[lsed_pkg::LW_W-1:0];
                    lsed_pkg::REG_CENTER_OFFSET:
                        ofs_q = pwdata[lsed_pkg::OFS_W-1:0];
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
                scan_pixel(smp.pixel, smp.last_pixel);
            if (res.valid && res.ready)
            begin
                if (reports_due.size() == 0)
                begin
                    report_mismatch("result beat with no frame pending");
                end
                else
                begin
                    due = reports_due.pop_front();
                    check_field("frame_kind", int'(res.frame_kind), int'(due.kind));
                    check_field("line_position", int'(res.line_position),
                                int'(due.position));
                    check_field("line_width", int'(res.line_width), int'(due.width));
                    check_field("edge_count", int'(res.edge_count), int'(due.count));
                    checked++;
                end
            end
            pending = reports_due.size();
        end
    end

endmodule

// ===== tb/sv/line_scan_edge_line_detector_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_scan_edge_line_detector_unit_test
// drives scan-line frames through the detector under several register
// settings and idle mixes; the frame checker beside the block predicts and
// compares, and this top gives the verdict
// ----------------------------------------------------------------------------
module line_scan_edge_line_detector_unit_test;

    localparam int ADDR_W = lsed_pkg::ADDR_W;
    localparam int DATA_W = lsed_pkg::DATA_W;
    localparam int PIX_W  = lsed_pkg::PIX_W;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lsed_sample_if smp ();
    lsed_result_if res ();

    int fails;
    int waiting;
    int checked_cnt;

    // idle mix of the current phase, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // register values in force, used to shape the frames
    int thr_set     = lsed_pkg::RST_EDGE_THRESHOLD;
    int margin_set  = lsed_pkg::RST_MARGIN;
    int min_lw_set  = lsed_pkg::RST_MIN_LINE_WIDTH;
    int max_lw_set  = lsed_pkg::RST_MAX_LINE_WIDTH;
    int min_gap_set = lsed_pkg::RST_MIN_START_GAP;
    int max_gap_set = lsed_pkg::RST_MAX_START_GAP;
    int ofs_set     = 0;

    int items_sent    = 0;
    int frames_sent   = 0;
    int settings_used = 1;

    logic [PIX_W-1:0] frame_px[$];

    line_scan_edge_line_detector_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp),
        .result  (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    line_scan_frame_checker frame_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .smp      (smp),
        .res      (res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .failures (fails),
        .pending  (waiting),
        .checked  (checked_cnt)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result receiver, stalls at random
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // register write: setup then access, starts and ends at a falling edge
    task automatic write_reg(input logic [lsed_pkg::RIDX_W-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // one pixel beat, with random idle cycles ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(negedge clk);
        end
        smp.valid      <= 1'b1;
        smp.pixel      <= pix;
        smp.last_pixel <= last;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // append a run of pixels around one level
    task automatic add_run(input int level, input int count, input int noise);
        int v;
        for (int i = 0; i < count; i++)
        begin
            v = level + $urandom_range(0, 2 * noise) - noise;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            frame_px.push_back(PIX_W'(v));
        end
    endtask

    // widths near the acceptance bounds, or anywhere
    function automatic int pick_width(input int lo, input int hi);
        int w;
        case ($urandom_range(0, 5))
            0: w = lo;
            1: w = lo + 1;
            2: w = hi - 1;
            3: w = hi;
            default: w = $urandom_range(1, 30);
        endcase
        if (w < 1)
            w = 1;
        if (w > 60)
            w = 60;
        return w;
    endfunction

    // build one random frame: mostly line and marker patterns, some noise
    task automatic shape_frame();
        int len;
        int c;
        int dark;
        int bright;
        int noise;
        int lead;
        int lvl;
        int r;
        frame_px.delete();
        r = $urandom_range(99);
        if (r < 25)
            len = 128;
        else if (r < 60)
            len = $urandom_range(20, 127);
        else if (r < 70)
            len = $urandom_range(129, 170);
        else
            len = $urandom_range(1, 19);

        c = thr_set + 1 + $urandom_range(0, 60);
        if (c > 255)
            c = 255;
        dark   = $urandom_range(0, 255 - c);
        bright = dark + c;
        noise  = $urandom_range(0, 3);
        if (2 * noise > thr_set)
            noise = thr_set / 2;
        lead = $urandom_range(0, 40) + ((margin_set <= 32) ? margin_set : 0);

        case ($urandom_range(0, 4))
            // dark line on a bright background
            0:
            begin
                add_run(bright, lead, noise);
                add_run(dark, pick_width(min_lw_set, max_lw_set), noise);
                lvl = bright;
            end
            // gap, line, gap
            1:
            begin
                add_run(dark, lead, noise);
                add_run(bright, pick_width(min_gap_set, max_gap_set), noise);
                add_run(dark, pick_width(min_lw_set, max_lw_set), noise);
                add_run(bright, pick_width(min_gap_set, max_gap_set), noise);
                lvl = dark;
            end
            // two lines
            2:
            begin
                add_run(bright, lead, noise);
                add_run(dark, pick_width(min_lw_set, max_lw_set), noise);
                add_run(bright, pick_width(min_gap_set, max_gap_set), noise);
                add_run(dark, pick_width(min_lw_set, max_lw_set), noise);
                lvl = bright;
            end
            // alternating runs of random length
            3:
            begin
                lvl = bright;
                while (frame_px.size() < len)
                begin
                    add_run(lvl, $urandom_range(1, 25), noise);
                    lvl = (lvl == bright) ? dark : bright;
                end
            end
            // raw noise, hits the edge limit when the threshold is low
            default:
            begin
                for (int i = 0; i < len; i++)
                    frame_px.push_back(PIX_W'($urandom_range(0, 255)));
                lvl = $urandom_range(0, 255);
            end
        endcase
        if (frame_px.size() < len)
            add_run(lvl, len - frame_px.size(), noise);
        while (frame_px.size() > len)
            void'(frame_px.pop_back());
    endtask

    // send the frame held in frame_px, last pixel marked, then drop valid
    task automatic play_frame();
        for (int i = 0; i < frame_px.size(); i++)
        begin
            send_pixel(frame_px[i], i == frame_px.size() - 1);
            items_sent++;
        end
        smp.valid      <= 1'b0;
        smp.last_pixel <= 1'b0;
        @(negedge clk);
        frames_sent++;
    endtask

    // stimulus
    initial
    begin
        int phase_items;
        int phase_frames;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        smp.valid      = 1'b0;
        smp.pixel      = '0;
        smp.last_pixel = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full-swing gap, line, gap, then a too-narrow line closed on the
        // last pixel
        add_run(0, 5, 0);
        add_run(255, 5, 0);
        add_run(0, 5, 0);
        add_run(255, 5, 0);
        add_run(0, 3, 0);
        add_run(255, 1, 0);
        play_frame();
        // frame of a single pixel
        frame_px.delete();
        add_run(255, 1, 0);
        play_frame();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase

            if (p > 0)
            begin
                // block idle before touching the registers
                while (waiting != 0)
                    @(negedge clk);
                repeat (4) @(negedge clk);
                case (p)
                    1:
                    begin
                        thr_set = 0;     margin_set = 0;
                        min_lw_set = 0;  max_lw_set = 127;
                        min_gap_set = 0; max_gap_set = 127;
                        ofs_set = -32;
                    end
                    2:
                    begin
                        thr_set = 255;     margin_set = 32;
                        min_lw_set = 127;  max_lw_set = 0;
                        min_gap_set = 127; max_gap_set = 0;
                        ofs_set = 32;
                    end
                    3:
                    begin
                        thr_set = 10;    margin_set = 63;
                        min_lw_set = 3;  max_lw_set = 20;
                        min_gap_set = 3; max_gap_set = 20;
                        ofs_set = -64;
                    end
                    default:
                    begin
                        thr_set     = $urandom_range(3, 80);
                        margin_set  = $urandom_range(0, 32);
                        min_lw_set  = $urandom_range(0, 8);
                        max_lw_set  = $urandom_range(10, 40);
                        min_gap_set = $urandom_range(0, 8);
                        max_gap_set = $urandom_range(10, 40);
                        ofs_set     = $urandom_range(0, 127) - 64;
                    end
                endcase
                write_reg(lsed_pkg::REG_EDGE_THRESHOLD, thr_set);
                write_reg(lsed_pkg::REG_MARGIN, margin_set);
                write_reg(lsed_pkg::REG_MIN_LINE_WIDTH, min_lw_set);
                write_reg(lsed_pkg::REG_MAX_LINE_WIDTH, max_lw_set);
                write_reg(lsed_pkg::REG_MIN_START_GAP, min_gap_set);
                write_reg(lsed_pkg::REG_MAX_START_GAP, max_gap_set);
                write_reg(lsed_pkg::REG_CENTER_OFFSET, ofs_set & 'h7F);
                settings_used++;
            end

            phase_items  = 0;
            phase_frames = 0;
            while (phase_items < 180 || phase_frames < 2)
            begin
                shape_frame();
                phase_items += frame_px.size();
                play_frame();
                phase_frames++;
                // hold off until every pending frame result is out
                if (p == 4 && phase_frames == 2)
                    while (waiting != 0)
                        @(negedge clk);
            end
        end

        // drain
        while (waiting != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("sent %0d pixel beats in %0d frames under %0d register settings",
                 items_sent, frames_sent, settings_used);
        $display("compared %0d frame results across four idle mixes", checked_cnt);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lsed_pkg.sv
sv/lsed_sample_if.sv
sv/lsed_result_if.sv
sv/lsed_edge_unit.sv
sv/line_scan_edge_line_detector_unit.sv
tb/sv/line_scan_frame_checker.sv
tb/sv/line_scan_edge_line_detector_unit_test.sv
